### hdl/lnd_pkg.sv
// Package for the line number delta/run encoder.
// Holds field widths, encoding constants, register indexes and the packed byte-group type.
// No dependencies.
`timescale 1ns / 1ps

package lnd_pkg;

    localparam int LINE_W  = 15;
    localparam int DELTA_W = 16;
    localparam int RUN_W   = 4;
    localparam int BYTE_W  = 8;
    localparam int CNT_W   = 2;
    localparam int MAX_BYTES = 3;

    localparam int APB_DW = 32;
    localparam int APB_AW = 3;

    // Register index of base_line (byte address 0).
    localparam logic REG_BASE_LINE = 1'b0;

    // Run count at which a pending pair is flushed even if the line is unchanged.
    localparam logic [RUN_W-1:0] RUN_MAX = 4'd8;

    // Deltas inside this window pack into a single byte.
    localparam logic signed [DELTA_W-1:0] SMALL_MIN = -16'sd7;
    localparam logic signed [DELTA_W-1:0] SMALL_MAX = 16'sd7;

    // Delta forced by an end item.
    localparam logic signed [DELTA_W-1:0] END_DELTA = 16'sd1;

    // Flag ORed into the count byte of the three-byte form.
    localparam logic [BYTE_W-1:0] ESC_FLAG = 8'h80;

    localparam logic [CNT_W-1:0] CNT_NONE  = 2'd0;
    localparam logic [CNT_W-1:0] CNT_SHORT = 2'd1;
    localparam logic [CNT_W-1:0] CNT_LONG  = 2'd3;

    // Bytes produced by one item; bytes[0] goes out first.
    typedef struct packed {
        logic [CNT_W-1:0]                    cnt;
        logic [MAX_BYTES-1:0][BYTE_W-1:0]    bytes;
    } t_pair;

endpackage

### hdl/lnd_if.sv
// Valid/ready channel interfaces for the line number delta/run encoder.
// Depends on lnd_pkg for the field widths.
`timescale 1ns / 1ps

interface lnd_in_if;
    import lnd_pkg::*;

    logic              valid;
    logic              ready;
    logic [LINE_W-1:0] line_number;
    logic              is_end;

    modport source (output valid, output line_number, output is_end, input ready);
    modport sink   (input valid, input line_number, input is_end, output ready);
endinterface

interface lnd_out_if;
    import lnd_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              last;

    modport source (output valid, output out_byte, output last, input ready);
    modport sink   (input valid, input out_byte, input last, output ready);
endinterface

### hdl/lnd_cfg.sv
// APB-style configuration register block holding base_line.
// Depends on lnd_pkg.
`timescale 1ns / 1ps

module lnd_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lnd_pkg::APB_AW-1:0]   paddr,
    input  logic [lnd_pkg::APB_DW-1:0]   pwdata,
    output logic [lnd_pkg::APB_DW-1:0]   prdata,
    output logic                         pready,
    output logic [lnd_pkg::LINE_W-1:0]   o_base_line
);
    import lnd_pkg::*;

    logic              sel_base;
    logic [LINE_W-1:0] r_base_line;

    assign sel_base = (paddr[APB_AW-1] == REG_BASE_LINE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_line <= '0;
        end else if (psel && penable && pwrite && sel_base) begin
            r_base_line <= pwdata[LINE_W-1:0];
        end
    end

    assign pready      = 1'b1;
    assign prdata      = sel_base ? {{(APB_DW-LINE_W){1'b0}}, r_base_line} : '0;
    assign o_base_line = r_base_line;

endmodule

### hdl/lnd_core.sv
// Input register, pending-pair state and delta/run encoding logic.
// Depends on lnd_pkg and lnd_in_if.
`timescale 1ns / 1ps

module lnd_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    lnd_in_if.sink                      i_in,
    input  logic [lnd_pkg::LINE_W-1:0]  i_base_line,
    input  logic                        i_free,
    output logic                        o_load,
    output lnd_pkg::t_pair              o_pair
);
    import lnd_pkg::*;

    logic                       r_in_valid;
    logic [LINE_W-1:0]          r_line;
    logic                       r_end;

    logic [LINE_W-1:0]          r_prev;
    logic signed [DELTA_W-1:0]  r_delta;
    logic [RUN_W-1:0]           r_run;
    logic                       r_pend;

    logic [LINE_W-1:0]          n_prev;
    logic signed [DELTA_W-1:0]  n_delta;
    logic [RUN_W-1:0]           n_run;
    logic                       n_pend;

    logic                       step;
    logic [LINE_W-1:0]          cur;
    logic [LINE_W-1:0]          eff_prev;
    logic signed [DELTA_W-1:0]  delta;
    logic                       emit;
    logic                       short_form;

    assign step        = r_in_valid && i_free;
    assign i_in.ready  = !r_in_valid || i_free;

    always_comb begin
        cur        = (r_line == '0) ? i_base_line : r_line;
        eff_prev   = r_pend ? r_prev : i_base_line;
        delta      = r_end ? END_DELTA
                           : $signed({1'b0, cur}) - $signed({1'b0, eff_prev});
        emit       = r_pend && ((delta != '0) || (r_run >= RUN_MAX));
        short_form = (r_delta >= SMALL_MIN) && (r_delta <= SMALL_MAX);

        o_pair.bytes = '0;
        if (!emit) begin
            o_pair.cnt = CNT_NONE;
        end else if (short_form) begin
            o_pair.cnt      = CNT_SHORT;
            o_pair.bytes[0] = {r_delta[3:0], r_run};
        end else begin
            o_pair.cnt      = CNT_LONG;
            o_pair.bytes[0] = ESC_FLAG | {{(BYTE_W-RUN_W){1'b0}}, r_run};
            o_pair.bytes[1] = r_delta[DELTA_W-1:BYTE_W];
            o_pair.bytes[2] = r_delta[BYTE_W-1:0];
        end

        n_prev  = r_prev;
        n_delta = r_delta;
        n_run   = r_run;
        n_pend  = r_pend;
        if (!r_pend) begin
            if (!r_end) begin
                n_pend  = 1'b1;
                n_delta = delta;
                n_run   = '0;
                n_prev  = cur;
            end
        end else if (emit) begin
            n_run   = '0;
            n_delta = delta;
            n_prev  = cur;
        end else begin
            n_run = r_run + 1'b1;
        end
        if (r_end) begin
            n_pend  = 1'b0;
            n_delta = '0;
            n_run   = '0;
        end
    end

    assign o_load = step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_pend     <= 1'b0;
            r_delta    <= '0;
            r_run      <= '0;
            r_prev     <= '0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_in_valid <= 1'b1;
            end else if (step) begin
                r_in_valid <= 1'b0;
            end
            if (step) begin
                r_pend  <= n_pend;
                r_delta <= n_delta;
                r_run   <= n_run;
                r_prev  <= n_prev;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_line <= i_in.line_number;
            r_end  <= i_in.is_end;
        end
    end

endmodule

### hdl/lnd_obuf.sv
// Output byte buffer: holds up to three encoded bytes and shifts them out one per transfer.
// Depends on lnd_pkg and lnd_out_if.
`timescale 1ns / 1ps

module lnd_obuf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  lnd_pkg::t_pair      i_pair,
    output logic                o_free,
    lnd_out_if.source           o_out
);
    import lnd_pkg::*;

    logic [MAX_BYTES-1:0][BYTE_W-1:0] r_bytes;
    logic [CNT_W-1:0]                 r_cnt;
    logic                             fire;

    assign fire   = (r_cnt != CNT_NONE) && o_out.ready;
    assign o_free = (r_cnt == CNT_NONE) || ((r_cnt == CNT_SHORT) && o_out.ready);

    assign o_out.valid    = (r_cnt != CNT_NONE);
    assign o_out.out_byte = r_bytes[0];
    assign o_out.last     = (r_cnt == CNT_SHORT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= CNT_NONE;
        end else if (i_load) begin
            r_cnt <= i_pair.cnt;
        end else if (fire) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bytes <= i_pair.bytes;
        end else if (fire) begin
            r_bytes <= {{BYTE_W{1'b0}}, r_bytes[MAX_BYTES-1:1]};
        end
    end

endmodule

### hdl/line_number_delta_run_encoder.sv
// Top level of the line number delta/run encoder.
// Depends on lnd_pkg, lnd_in_if, lnd_out_if, lnd_cfg, lnd_core and lnd_obuf.
`timescale 1ns / 1ps

//  Channel | Direction | Payload                     | Handshake
//  --------+-----------+-----------------------------+----------------------
//  i_in    | in        | line_number[14:0], is_end   | valid/ready
//  o_out   | out       | out_byte[7:0], last         | valid/ready
//  APB     | in/out    | base_line at byte address 0 | psel/penable, pready=1
//
// An item waits in the input register until the buffer is free; its bytes are then
// loaded and appear on o_out in the cycle after. Items that yield no byte or one
// byte stream at one per cycle while o_out is ready. An item that flushes an
// escaped delta holds back the next one while the byte-wide output buffer drains
// its three bytes. Reset (synchronous, active low) clears the pending pair, the
// run count, the buffer and base_line. A stall on o_out holds the buffer and,
// once it is full, the input register, which then drops i_in.ready.

module line_number_delta_run_encoder (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    lnd_in_if.sink                      i_in,
    lnd_out_if.source                   o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lnd_pkg::APB_AW-1:0]  paddr,
    input  logic [lnd_pkg::APB_DW-1:0]  pwdata,
    output logic [lnd_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);
    import lnd_pkg::*;

    logic [LINE_W-1:0] base_line;
    logic              free;
    logic              load;
    t_pair             pair;

    // The base_line register; the user must change it only while the encoder is idle, as the block does not enforce it.
    lnd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_base_line (base_line)
    );

    // The core keeps the previous line, the pending delta and the run count.
    // It processes its registered item whenever the buffer can take the
    // resulting bytes, and hands them over as one group.
    lnd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_base_line (base_line),
        .i_free      (free),
        .o_load      (load),
        .o_pair      (pair)
    );

    // The buffer presents the bytes one transfer at a time and marks the
    // final byte of each group with last.
    lnd_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_pair  (pair),
        .o_free  (free),
        .o_out   (o_out)
    );

endmodule

### sim/line_number_delta_run_encoder_tb.sv
// Self-checking testbench for line_number_delta_run_encoder.
// Depends on lnd_pkg, the lnd_in_if/lnd_out_if channel interfaces and the encoder RTL.
`timescale 1ns / 1ps

module line_number_delta_run_encoder_tb;
    import lnd_pkg::*;

    // Clock period and bounds on how long the run may take.
    localparam int  CLK_PERIOD   = 10;
    localparam int  SETTLE_LOOPS = 12;        // cycles allowed after the queue empties
    localparam int  MAX_REPORTS  = 40;        // mismatch lines printed before going quiet
    localparam time RUN_LIMIT    = 3_000_000; // ns, far beyond the slowest correct run

    // Register indexes; the second one is not decoded by the block.
    localparam int REG_IDX_BASE   = int'(REG_BASE_LINE);
    localparam int REG_IDX_UNUSED = 1;

    localparam logic [LINE_W-1:0] LINE_MAX = '1;

    // One byte of the compressed line table as it should leave the block.
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } enc_byte_t;

    logic i_clk;
    logic i_rst_n;

    lnd_in_if  in_if();
    lnd_out_if out_if();

    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    line_number_delta_run_encoder i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Local copy of the encoder state, updated on every accepted transfer.
    logic [LINE_W-1:0]         base_reg    = '0;
    logic [DELTA_W-1:0]        last_line   = '0;
    logic signed [DELTA_W-1:0] held_delta  = '0;
    logic [RUN_W-1:0]          repeat_cnt  = '0;
    logic                      held_valid  = 1'b0;

    // Bytes that the block still owes, oldest first.
    enc_byte_t expected_bytes[$];

    int err_count     = 0;
    int src_idle_pct  = 25;   // chance in a hundred that the sender pauses before an item
    int snk_idle_pct  = 25;   // chance in a hundred that the receiver drops ready
    int holdoff_left  = 0;    // cycles of forced receiver stall still to run

    initial i_clk = 1'b0;
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Every mismatch goes through here so that it is counted once and printed at most once.
    task automatic report_mismatch(input string msg);
        err_count++;
        if (err_count <= MAX_REPORTS) begin
            $display("[%0t] MISMATCH: %s", $time, msg);
        end
    endtask

    // Return the tracked state to the start of a procedure.
    task automatic clear_line_state();
        last_line  = {1'b0, base_reg};
        held_delta = '0;
        repeat_cnt = '0;
        held_valid = 1'b0;
    endtask

    // Queue the bytes of the pending (delta, count) pair.
    task automatic emit_held_pair();
        enc_byte_t b;
        if (held_delta >= SMALL_MIN && held_delta <= SMALL_MAX) begin
            b.data = {held_delta[3:0], repeat_cnt};
            b.last = 1'b1;
            expected_bytes.push_back(b);
        end else begin
            b.data = {{(BYTE_W-RUN_W){1'b0}}, repeat_cnt} | ESC_FLAG;
            b.last = 1'b0;
            expected_bytes.push_back(b);
            b.data = held_delta[15:8];
            expected_bytes.push_back(b);
            b.data = held_delta[7:0];
            b.last = 1'b1;
            expected_bytes.push_back(b);
        end
    endtask

    // Work out what one accepted line entry does to the state and which bytes it emits.
    task automatic encode_line_item(input logic [LINE_W-1:0] line, input logic end_mark);
        logic [DELTA_W-1:0]        from_line;
        logic [DELTA_W-1:0]        cur_line;
        logic signed [DELTA_W-1:0] delta;
        from_line = held_valid ? last_line : {1'b0, base_reg};
        cur_line  = (line == '0) ? {1'b0, base_reg} : {1'b0, line};
        delta     = end_mark ? END_DELTA : DELTA_W'(int'(cur_line) - int'(from_line));

        if (!held_valid) begin
            // The first entry of a procedure only opens the pending pair.
            if (end_mark) begin
                clear_line_state();
            end else begin
                held_valid = 1'b1;
                held_delta = delta;
                repeat_cnt = '0;
                last_line  = cur_line;
            end
        end else begin
            if (delta != '0 || repeat_cnt >= RUN_MAX) begin
                emit_held_pair();
                repeat_cnt = '0;
                held_delta = delta;
                last_line  = from_line + delta;
            end else begin
                repeat_cnt = repeat_cnt + 1'b1;
            end
            if (end_mark) begin
                clear_line_state();
            end
        end
    endtask

    // Compare every byte the block hands over with the oldest one owed.
    always @(posedge i_clk) begin : check_bytes
        enc_byte_t want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (expected_bytes.size() == 0) begin
                report_mismatch($sformatf("unexpected byte 0x%02h last=%0b",
                                          out_if.out_byte, out_if.last));
            end else begin
                want = expected_bytes.pop_front();
                if (out_if.out_byte !== want.data) begin
                    report_mismatch($sformatf("out_byte 0x%02h, wanted 0x%02h",
                                              out_if.out_byte, want.data));
                end
                if (out_if.last !== want.last) begin
                    report_mismatch($sformatf("last %0b, wanted %0b (byte 0x%02h)",
                                              out_if.last, want.last, want.data));
                end
            end
        end
    end

    // Receiver side: a forced hold-off takes priority over the random stalls.
    always @(negedge i_clk) begin
        if (holdoff_left > 0) begin
            out_if.ready <= 1'b0;
            holdoff_left--;
        end else begin
            out_if.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // Offer one line entry and hold it until the block takes it. Entered and left at a
    // falling edge; valid is left high so back-to-back items need no extra step.
    task automatic send_line(input logic [LINE_W-1:0] line, input logic end_mark);
        if ($urandom_range(99) < src_idle_pct) begin
            in_if.valid       <= 1'b0;
            in_if.line_number <= LINE_W'($urandom);
            in_if.is_end      <= 1'($urandom);
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.line_number <= line;
        in_if.is_end      <= end_mark;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        encode_line_item(line, end_mark);
        @(negedge i_clk);
    endtask

    // Stop offering items, then wait until the block owes nothing and has gone quiet.
    task automatic wait_for_drain();
        in_if.valid <= 1'b0;
        while (expected_bytes.size() != 0) @(negedge i_clk);
        repeat (SETTLE_LOOPS) @(negedge i_clk);
    endtask

    // APB write of one register followed by a read-back of base_line. The block must be
    // idle; upper data bits are random because the register keeps only the low 15.
    task automatic write_register(input int idx, input logic [LINE_W-1:0] value);
        logic [APB_DW-1:0] data;
        data = {$urandom} & ~APB_DW'(LINE_MAX);
        data = data | APB_DW'(value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'(idx * 4);
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (idx == REG_IDX_BASE) begin
            base_reg = value;
            if (!held_valid) begin
                last_line = {1'b0, base_reg};
            end
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        paddr   <= APB_AW'(REG_IDX_BASE * 4);
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata[LINE_W-1:0] !== base_reg) begin
            report_mismatch($sformatf("base_line read 0x%04h, wanted 0x%04h",
                                      prdata[LINE_W-1:0], base_reg));
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Hand-picked entries: long runs, the edges of the one-byte window, the largest
    // deltas, zero entries, and end marks with and without a pending pair.
    task automatic test_directed_lines();
        write_register(REG_IDX_BASE, LINE_W'(100));
        send_line('0, 1'b0);                       // opens the procedure at the base line
        repeat (10) send_line(LINE_W'(100), 1'b0); // run reaches 8 and is flushed with delta 0
        send_line(LINE_W'(107), 1'b0);             // +7, still one byte
        send_line(LINE_W'(100), 1'b0);             // -7
        send_line(LINE_W'(108), 1'b0);             // +8 needs the escaped form
        send_line(LINE_W'(100), 1'b0);             // -8
        send_line(LINE_MAX, 1'b0);                 // largest upward jump
        send_line(LINE_W'(1), 1'b0);               // largest downward jump
        send_line('0, 1'b0);                       // zero stands for the base line
        send_line('0, 1'b0);
        send_line(LINE_W'(15'h2AAA), 1'b1);        // end flushes; its line is ignored
        send_line(LINE_W'(15'h5555), 1'b1);        // end with nothing pending
        send_line(LINE_MAX, 1'b0);
        send_line(LINE_MAX, 1'b1);
        wait_for_drain();
    endtask

    // The register changes between two items of one procedure: only later zero
    // entries and the next procedure see the new base.
    task automatic test_base_change_mid_procedure();
        write_register(REG_IDX_BASE, LINE_W'(500));
        send_line(LINE_W'(510), 1'b0);
        send_line('0, 1'b0);
        wait_for_drain();
        write_register(REG_IDX_BASE, LINE_W'(20000));
        write_register(REG_IDX_UNUSED, LINE_W'(321));   // undecoded, must change nothing
        send_line('0, 1'b0);
        send_line('0, 1'b0);
        send_line(LINE_W'(520), 1'b0);
        send_line('0, 1'b1);
        send_line('0, 1'b0);                            // next procedure starts at the new base
        send_line('0, 1'b1);
        wait_for_drain();
    endtask

    // The receiver stalls for a long stretch while escaped deltas keep coming, so the
    // output buffer fills and the block has to push back on its input.
    task automatic test_output_stall();
        src_idle_pct = 0;
        holdoff_left = 150;
        for (int k = 0; k < 30; k++) begin
            send_line((k % 2 == 0) ? LINE_W'(30000 - k) : LINE_W'(40 + k), 1'b0);
        end
        send_line('0, 1'b1);
        wait_for_drain();
        src_idle_pct = 25;
    endtask

    // Pick a line near the current one; mostly well-formed procedure content.
    function automatic logic [LINE_W-1:0] next_line(input logic [LINE_W-1:0] cur);
        int pick;
        int step;
        int cand;
        pick = $urandom_range(99);
        if (pick < 40) begin
            step = 0;
        end else if (pick < 75) begin
            step = $urandom_range(1, 7);
        end else begin
            step = $urandom_range(8, 300);
        end
        if ($urandom_range(1)) step = -step;
        cand = int'(cur) + step;
        if (pick >= 95 || cand < 1 || cand > int'(LINE_MAX)) begin
            cand = $urandom_range(1, int'(LINE_MAX));
        end
        return LINE_W'(cand);
    endfunction

    // Random procedures: runs, small and large steps, zero entries, then an end mark.
    // A small share of the items is noise: stray ends and arbitrary lines.
    task automatic test_random_procedures(input int item_goal);
        int                sent;
        int                len;
        logic [LINE_W-1:0] cur;
        sent = 0;
        while (sent < item_goal) begin
            if ($urandom_range(99) < 85) begin
                len = $urandom_range(1, 16);
                cur = ($urandom_range(3) == 0) ? base_reg : LINE_W'($urandom_range(1, 32767));
                if (cur == '0) cur = LINE_W'(1);
                for (int k = 0; k < len && sent < item_goal; k++) begin
                    if ($urandom_range(9) == 0) begin
                        // A long run on one line may cross the count limit.
                        repeat ($urandom_range(6, 12)) begin
                            send_line(cur, 1'b0);
                            sent++;
                        end
                    end else if ($urandom_range(9) == 0) begin
                        send_line('0, 1'b0);
                        cur = (base_reg == '0) ? cur : base_reg;
                        sent++;
                    end else begin
                        cur = next_line(cur);
                        send_line(cur, 1'b0);
                        sent++;
                    end
                end
                send_line(LINE_W'($urandom), 1'b1);
                sent++;
            end else begin
                send_line(LINE_W'($urandom), 1'($urandom_range(3) == 0));
                sent++;
            end
        end
        wait_for_drain();
    endtask

    initial begin
        i_rst_n           = 1'b0;
        in_if.valid       = 1'b0;
        in_if.line_number = '0;
        in_if.is_end      = 1'b0;
        out_if.ready      = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed_lines();
        test_base_change_mid_procedure();
        test_output_stall();

        write_register(REG_IDX_BASE, LINE_W'($urandom));
        test_random_procedures(100);

        // A long stretch with neither side idling, at the top base value.
        src_idle_pct = 0;
        snk_idle_pct = 0;
        write_register(REG_IDX_BASE, LINE_MAX);
        test_random_procedures(60);

        src_idle_pct = 25;
        snk_idle_pct = 25;
        write_register(REG_IDX_BASE, '0);
        test_random_procedures(100);

        if (err_count == 0) begin
            $display("line_number_delta_run_encoder regression: pass");
        end else begin
            $display("line_number_delta_run_encoder regression: fail");
        end
        $finish;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        #(RUN_LIMIT);
        $display("line_number_delta_run_encoder regression: fail");
        $finish;
    end

endmodule

### sim.f
hdl/lnd_pkg.sv
hdl/lnd_if.sv
hdl/lnd_cfg.sv
hdl/lnd_core.sv
hdl/lnd_obuf.sv
hdl/line_number_delta_run_encoder.sv
sim/line_number_delta_run_encoder_tb.sv
